### design/dagl_pkg.sv
package dagl_pkg;

    localparam int MAX_NODES  = 32;
    localparam int MAX_EDGES  = 64;

    localparam int FIELD_W    = 6;
    localparam int IDX_W      = 5;
    localparam int X_W        = 10;
    localparam int Y_W        = 8;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
    localparam int LANE_W     = NODE_W + 1;

    localparam int X_STEP     = 27;
    localparam int Y_STEP     = 5;
    localparam int X_PAD      = 22;
    localparam int Y_PAD      = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2,
        ST_CYCLE    = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_RUN  = 1'b1
    } t_func;

    typedef struct packed {
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] src;
    } t_edge;

    typedef struct packed {
        logic [EDGE_CNT_W-1:0] deg;
        logic [NODE_W-1:0]     depth;
        logic                  placed;
    } t_node;

    typedef struct packed {
        logic [Y_W-1:0]   ext_h;
        logic [X_W-1:0]   ext_w;
        logic [Y_W-1:0]   pos_y;
        logic [X_W-1:0]   pos_x;
        logic [IDX_W-1:0] idx;
    } t_res;

    typedef struct packed {
        logic    node_valid;
        t_res    res;
        t_status status;
        logic    last;
    } t_out;

endpackage

### design/dagl_out_stage.sv
module dagl_out_stage
    import dagl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_item,
    output logic o_free,
    input  logic i_ready,
    output logic o_valid,
    output t_out o_item
);

    logic r_valid;
    t_out r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_item <= i_item;
        end
    end

endmodule

### design/dag_layer_layout.sv
// Edge load beat: stored while the store has room, no result. Run beat: clear sweep of the
// node and lane tables, in-degree counting per edge, then per placed node a node scan, a
// pass over the stored edges and the lane update; results then leave one at a time, held
// while the output stage is busy; a failure gives one status result. Each node table and
// the edge store has one read port. One item is worked at a time. Synchronous active-low
// reset clears control, counts, flags and the node limit; the edge store is not cleared.
module dag_layer_layout
    import dagl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [FIELD_W-1:0]   i_cfg_data,    // node_limit
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [15:0]          i_s_tdata,     // edge_from, edge_to
    input  logic                 i_s_tuser,     // func
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,     // node_index, pos_x, pos_y, extent_width,
                                                // extent_height
    output logic [2:0]           o_m_tuser,     // node_valid, status
    output logic                 o_m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_DEG_RD, S_DEG_NODE, S_DEG_WR, S_CHECK, S_SRCH, S_SRCH_CHK,
        S_EDGE_RD, S_EDGE_CHK, S_EDGE_WR, S_LANE_RD, S_LANE_WR, S_DRAIN_RD, S_DRAIN_LD,
        S_FAIL
    } t_state;

    t_state                r_state;
    logic [FIELD_W-1:0]    r_nc;
    logic [FIELD_W-1:0]    r_run_nc;
    logic [EDGE_CNT_W-1:0] r_loaded;
    logic                  r_ovf;
    logic                  r_rng;
    logic                  r_err;
    t_status               r_status;
    logic [EDGE_CNT_W-1:0] r_j;
    logic [LANE_W-1:0]     r_k;
    logic [LANE_W-1:0]     r_placed_n;
    logic [NODE_W-1:0]     r_nxt;
    logic [NODE_W-1:0]     r_dnxt;
    logic [X_W-1:0]        r_w;
    logic [Y_W-1:0]        r_h;

    t_edge                 r_edge_mem [MAX_EDGES];
    t_node                 r_node_mem [MAX_NODES];
    logic [LANE_W-1:0]     r_lane_mem [MAX_NODES];
    t_res                  r_res_mem  [MAX_NODES];
    t_edge                 r_edge_q;
    t_node                 r_node_q;
    logic [LANE_W-1:0]     r_lane_q;
    t_res                  r_res_q;

    logic                  w_in_acc;
    t_edge                 w_in_edge;
    logic                  w_edge_we;
    logic [NODE_W-1:0]     w_node_raddr;
    logic                  w_node_we;
    logic [NODE_W-1:0]     w_node_waddr;
    t_node                 w_node_wdata;
    logic                  w_lane_we;
    logic [NODE_W-1:0]     w_lane_waddr;
    logic [LANE_W-1:0]     w_lane_wdata;
    logic                  w_found;
    logic [NODE_W-1:0]     w_dst;
    logic [X_W-1:0]        w_x;
    logic [Y_W-1:0]        w_y;
    logic [X_W-1:0]        w_xe;
    logic [Y_W-1:0]        w_ye;
    logic [X_W-1:0]        w_w;
    logic [Y_W-1:0]        w_h;
    t_res                  w_res;
    logic                  w_push;
    t_out                  w_out;
    logic                  w_out_free;
    logic                  w_out_valid;
    t_out                  w_out_q;
    logic                  w_drain_last;
    logic                  w_nc_big;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_in_edge   = '{dst: i_s_tdata[2*FIELD_W-1:FIELD_W], src: i_s_tdata[FIELD_W-1:0]};
    assign w_edge_we   = w_in_acc && (i_s_tuser == FUNC_LOAD)
                         && (r_loaded < EDGE_CNT_W'(MAX_EDGES));

    assign w_dst   = r_edge_q.dst[NODE_W-1:0];
    assign w_found = !r_node_q.placed && (r_node_q.deg == '0);
    assign w_nc_big = ({1'b0, r_run_nc} > (FIELD_W+1)'(MAX_NODES));

    assign w_x  = X_W'(r_dnxt) * X_W'(X_STEP);
    assign w_y  = Y_W'(r_lane_q) * Y_W'(Y_STEP);
    assign w_xe = w_x + X_W'(X_PAD);
    assign w_ye = w_y + Y_W'(Y_PAD);
    assign w_w  = (w_xe > r_w) ? w_xe : r_w;
    assign w_h  = (w_ye > r_h) ? w_ye : r_h;
    assign w_res = '{ext_h: w_h, ext_w: w_w, pos_y: w_y, pos_x: w_x, idx: IDX_W'(r_nxt)};
    assign w_drain_last = ((r_k + LANE_W'(1)) == r_placed_n);

    always_comb begin
        w_node_raddr = r_k[NODE_W-1:0];
        w_node_we    = 1'b0;
        w_node_waddr = r_k[NODE_W-1:0];
        w_node_wdata = '0;
        w_lane_we    = 1'b0;
        w_lane_waddr = r_dnxt;
        w_lane_wdata = r_lane_q + LANE_W'(1);
        case (r_state)
            S_CLR: begin
                w_node_we    = 1'b1;
                w_lane_we    = 1'b1;
                w_lane_waddr = r_k[NODE_W-1:0];
                w_lane_wdata = '0;
            end
            S_DEG_NODE, S_EDGE_CHK: begin
                w_node_raddr = w_dst;
            end
            S_DEG_WR: begin
                w_node_we        = 1'b1;
                w_node_waddr     = w_dst;
                w_node_wdata     = r_node_q;
                w_node_wdata.deg = r_node_q.deg + EDGE_CNT_W'(1);
            end
            S_SRCH_CHK: begin
                w_node_we           = w_found;
                w_node_wdata        = r_node_q;
                w_node_wdata.placed = 1'b1;
            end
            S_EDGE_WR: begin
                w_node_we        = 1'b1;
                w_node_waddr     = w_dst;
                w_node_wdata     = r_node_q;
                w_node_wdata.deg = r_node_q.deg - EDGE_CNT_W'(1);
                if (r_node_q.depth <= r_dnxt) begin
                    w_node_wdata.depth = r_dnxt + NODE_W'(1);
                end
            end
            S_LANE_WR: begin
                w_lane_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_push = 1'b0;
        w_out  = '{node_valid: 1'b0, res: '0, status: r_status, last: 1'b1};
        case (r_state)
            S_DRAIN_LD: begin
                w_push = 1'b1;
                w_out  = '{node_valid: 1'b1, res: r_res_q, status: ST_OK, last: w_drain_last};
            end
            S_FAIL: begin
                w_push = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            r_edge_mem[r_loaded[EDGE_AW-1:0]] <= w_in_edge;
        end
        r_edge_q <= r_edge_mem[r_j[EDGE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= w_node_wdata;
        end
        r_node_q <= r_node_mem[w_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_lane_we) begin
            r_lane_mem[w_lane_waddr] <= w_lane_wdata;
        end
        r_lane_q <= r_lane_mem[r_dnxt];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LANE_WR) begin
            r_res_mem[r_placed_n[NODE_W-1:0]] <= w_res;
        end
        r_res_q <= r_res_mem[r_k[NODE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nc       <= '0;
            r_run_nc   <= '0;
            r_loaded   <= '0;
            r_ovf      <= 1'b0;
            r_rng      <= 1'b0;
            r_err      <= 1'b0;
            r_status   <= ST_OK;
            r_j        <= '0;
            r_k        <= '0;
            r_placed_n <= '0;
            r_nxt      <= '0;
            r_dnxt     <= '0;
            r_w        <= '0;
            r_h        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_nc <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_tuser == FUNC_LOAD) begin
                            if (!w_edge_we) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_loaded <= r_loaded + EDGE_CNT_W'(1);
                                if (w_in_edge.src >= r_nc || w_in_edge.dst >= r_nc) begin
                                    r_rng <= 1'b1;
                                end
                            end
                        end else begin
                            r_run_nc   <= r_nc;
                            r_k        <= '0;
                            r_err      <= 1'b0;
                            r_status   <= ST_OK;
                            r_placed_n <= '0;
                            r_w        <= '0;
                            r_h        <= '0;
                            r_state    <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    r_k <= r_k + LANE_W'(1);
                    if (r_k == LANE_W'(MAX_NODES - 1)) begin
                        r_j     <= '0;
                        r_state <= S_DEG_RD;
                    end
                end
                S_DEG_RD: begin
                    r_state <= (r_j == r_loaded) ? S_CHECK : S_DEG_NODE;
                end
                S_DEG_NODE: begin
                    if (r_edge_q.src >= r_run_nc || r_edge_q.dst >= r_run_nc) begin
                        r_err <= 1'b1;
                    end
                    r_state <= S_DEG_WR;
                end
                S_DEG_WR: begin
                    r_j     <= r_j + EDGE_CNT_W'(1);
                    r_state <= S_DEG_RD;
                end
                S_CHECK: begin
                    r_k <= '0;
                    if (r_ovf) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_FAIL;
                    end else if (r_rng || r_err || w_nc_big) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_FAIL;
                    end else if (r_run_nc == '0) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (w_found) begin
                        r_nxt   <= r_k[NODE_W-1:0];
                        r_dnxt  <= r_node_q.depth;
                        r_j     <= '0;
                        r_state <= S_EDGE_RD;
                    end else if (FIELD_W'(r_k) + FIELD_W'(1) == r_run_nc) begin
                        r_status <= ST_CYCLE;
                        r_state  <= S_FAIL;
                    end else begin
                        r_k     <= r_k + LANE_W'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_EDGE_RD: begin
                    r_state <= (r_j == r_loaded) ? S_LANE_RD : S_EDGE_CHK;
                end
                S_EDGE_CHK: begin
                    if (r_edge_q.src == FIELD_W'(r_nxt)) begin
                        r_state <= S_EDGE_WR;
                    end else begin
                        r_j     <= r_j + EDGE_CNT_W'(1);
                        r_state <= S_EDGE_RD;
                    end
                end
                S_EDGE_WR: begin
                    r_j     <= r_j + EDGE_CNT_W'(1);
                    r_state <= S_EDGE_RD;
                end
                S_LANE_RD: begin
                    r_state <= S_LANE_WR;
                end
                S_LANE_WR: begin
                    r_w        <= w_w;
                    r_h        <= w_h;
                    r_placed_n <= r_placed_n + LANE_W'(1);
                    r_k        <= '0;
                    if (FIELD_W'(r_placed_n) + FIELD_W'(1) == r_run_nc) begin
                        r_state <= S_DRAIN_RD;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_DRAIN_RD: begin
                    r_state <= S_DRAIN_LD;
                end
                S_DRAIN_LD: begin
                    if (w_out_free) begin
                        if (w_drain_last) begin
                            r_loaded <= '0;
                            r_ovf    <= 1'b0;
                            r_rng    <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_k     <= r_k + LANE_W'(1);
                            r_state <= S_DRAIN_RD;
                        end
                    end
                end
                S_FAIL: begin
                    if (w_out_free) begin
                        r_loaded <= '0;
                        r_ovf    <= 1'b0;
                        r_rng    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    dagl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_out),
        .o_free  (w_out_free),
        .i_ready (i_m_tready),
        .o_valid (w_out_valid),
        .o_item  (w_out_q)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {7'b0, w_out_q.res};
    assign o_m_tuser  = {w_out_q.status, w_out_q.node_valid};
    assign o_m_tlast  = w_out_q.last;

`ifndef SYNTHESIS
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= EDGE_CNT_W'(MAX_EDGES))
        else $error("edge count past store depth");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == FUNC_RUN) |=> (r_state == S_CLR))
        else $error("run beat did not start clear sweep");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_LD) |-> (FIELD_W'(r_placed_n) == r_run_nc))
        else $error("drain with incomplete placement");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_out_free && w_out.last) |=> (r_state == S_IDLE && r_loaded == '0))
        else $error("run end did not empty edge store");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_out.node_valid) |-> (w_out.res == '0 && w_out.last))
        else $error("failure result carries payload");
`endif

endmodule

### tb/dag_layer_layout_tb.sv
`default_nettype none

module dag_layer_layout_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dagl_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int IDLE_PCT     = 6;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_WAIT  = 40;

    typedef struct packed {
        t_func      func;
        logic [5:0] src;
        logic [5:0] dst;
    } t_edge_beat;

    typedef struct packed {
        logic             placed;
        logic [IDX_W-1:0] node;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [X_W-1:0]   width;
        logic [Y_W-1:0]   height;
        t_status          status;
        logic             last;
    } t_placement;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    dag_layer_layout DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_edge_beat pending_beats[$];
    t_placement placements_q[$];

    logic [5:0] stored_src[MAX_EDGES];
    logic [5:0] stored_dst[MAX_EDGES];
    int         stored_cnt = 0;
    bit         overflow_seen = 0;
    bit         range_seen = 0;
    int         node_limit_m = 0;

    int  perm[MAX_NODES];
    int  queued = 0;
    int  beats_in = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  hold_rx = 0;
    wire calm = (beats_in >= 90) && (beats_in < 140);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic predict_placements(input t_func f, input logic [5:0] src,
                                      input logic [5:0] dst);
        int         deg[MAX_NODES];
        int         lvl[MAX_NODES];
        int         lanes[MAX_NODES];
        bit         done[MAX_NODES];
        t_placement recs[$];
        t_placement r;
        t_status    st;
        int         nc, nxt, d, lv, x, y, ext_w, ext_h;
        nc = node_limit_m;
        if (f == FUNC_LOAD) begin
            if (stored_cnt >= MAX_EDGES) begin
                overflow_seen = 1;
            end else begin
                if (int'(src) >= nc || int'(dst) >= nc)
                    range_seen = 1;
                stored_src[stored_cnt] = src;
                stored_dst[stored_cnt] = dst;
                stored_cnt++;
            end
        end else begin
            foreach (deg[k]) begin
                deg[k] = 0;
                lvl[k] = 0;
                lanes[k] = 0;
                done[k] = 0;
            end
            ext_w = 0;
            ext_h = 0;
            st = ST_OK;
            if (overflow_seen)
                st = ST_OVERFLOW;
            else if (range_seen || nc > MAX_NODES)
                st = ST_RANGE;
            else
                for (int j = 0; j < stored_cnt; j++)
                    if (int'(stored_src[j]) >= nc || int'(stored_dst[j]) >= nc)
                        st = ST_RANGE;
            if (st == ST_OK)
                for (int j = 0; j < stored_cnt; j++)
                    deg[int'(stored_dst[j]) % MAX_NODES]++;
            for (int i = 0; i < nc && st == ST_OK; i++) begin
                nxt = -1;
                for (int k = nc - 1; k >= 0; k--)
                    if (!done[k] && deg[k] == 0)
                        nxt = k;
                if (nxt < 0) begin
                    st = ST_CYCLE;
                end else begin
                    done[nxt] = 1;
                    for (int j = 0; j < stored_cnt; j++) begin
                        if (int'(stored_src[j]) == nxt) begin
                            d = int'(stored_dst[j]) % MAX_NODES;
                            deg[d]--;
                            if (lvl[d] <= lvl[nxt])
                                lvl[d] = lvl[nxt] + 1;
                        end
                    end
                    lv = lvl[nxt] % MAX_NODES;
                    x = lvl[nxt] * X_STEP;
                    y = lanes[lv] * Y_STEP;
                    lanes[lv]++;
                    if (x + X_PAD > ext_w)
                        ext_w = x + X_PAD;
                    if (y + Y_PAD > ext_h)
                        ext_h = y + Y_PAD;
                    r.placed = 1'b1;
                    r.node   = nxt[IDX_W-1:0];
                    r.x      = x[X_W-1:0];
                    r.y      = y[Y_W-1:0];
                    r.width  = ext_w[X_W-1:0];
                    r.height = ext_h[Y_W-1:0];
                    r.status = ST_OK;
                    r.last   = 1'b0;
                    recs.push_back(r);
                end
            end
            stored_cnt = 0;
            overflow_seen = 0;
            range_seen = 0;
            if (st != ST_OK || recs.size() == 0) begin
                r = '0;
                r.status = st;
                r.last = 1'b1;
                placements_q.push_back(r);
            end else begin
                recs[recs.size()-1].last = 1'b1;
                foreach (recs[k])
                    placements_q.push_back(recs[k]);
            end
        end
    endtask

    // drive input beats
    always @(posedge i_clk) begin : drive_edges
        t_edge_beat b;
        bit         idle;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_placements(t_func'(i_s_tuser), i_s_tdata[5:0], i_s_tdata[11:6]);
                beats_in++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                idle = !calm && ($urandom_range(99, 0) < IDLE_PCT);
                if (pending_beats.size() > 0 && !idle) begin
                    b = pending_beats.pop_front();
                    i_s_tdata  <= {4'b0, b.dst, b.src};
                    i_s_tuser  <= b.func;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= !hold_rx && (calm || $urandom_range(99, 0) >= IDLE_PCT);
    end

    // check result beats
    always @(posedge i_clk) begin : check_results
        t_placement want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (placements_q.size() == 0) begin
                report_mismatch("unexpected beat, node_index", 16'(o_m_tdata[4:0]), 16'(0));
            end else begin
                want = placements_q.pop_front();
                check_field("node_valid",    16'(o_m_tuser[0]),     16'(want.placed));
                check_field("status",        16'(o_m_tuser[2:1]),   16'(want.status));
                check_field("node_index",    16'(o_m_tdata[4:0]),   16'(want.node));
                check_field("pos_x",         16'(o_m_tdata[14:5]),  16'(want.x));
                check_field("pos_y",         16'(o_m_tdata[22:15]), 16'(want.y));
                check_field("extent_width",  16'(o_m_tdata[32:23]), 16'(want.width));
                check_field("extent_height", 16'(o_m_tdata[40:33]), 16'(want.height));
                check_field("last",          16'(o_m_tlast),        16'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int runs_pending();
        int n;
        n = 0;
        foreach (pending_beats[k])
            if (pending_beats[k].func == FUNC_RUN)
                n++;
        return n;
    endfunction

    // hold off the result side while loads keep coming
    initial begin
        do @(negedge i_clk);
        while (results_seen < 40 || runs_pending() < 3);
        hold_rx = 1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_rx = 0;
    end

    task automatic push_edge(input int src, input int dst);
        t_edge_beat b;
        b.func = FUNC_LOAD;
        b.src  = src[5:0];
        b.dst  = dst[5:0];
        pending_beats.push_back(b);
        queued++;
    endtask

    task automatic push_run();
        t_edge_beat b;
        b.func = FUNC_RUN;
        b.src  = 6'($urandom_range(63, 0));
        b.dst  = 6'($urandom_range(63, 0));
        pending_beats.push_back(b);
        queued++;
    endtask

    task automatic push_dag(input int nc, input int n_edges);
        int a, b, t;
        for (int i = 0; i < MAX_NODES; i++)
            perm[i] = i;
        for (int i = nc - 1; i > 0; i--) begin
            a = $urandom_range(i, 0);
            t = perm[i];
            perm[i] = perm[a];
            perm[a] = t;
        end
        if (nc >= 2) begin
            repeat (n_edges) begin
                a = $urandom_range(nc - 2, 0);
                b = $urandom_range(nc - 1, a + 1);
                push_edge(perm[a], perm[b]);
            end
        end
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_s_tvalid || placements_q.size() != 0);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic set_node_limit(input int value);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[5:0];
        do @(negedge i_clk);
        while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        node_limit_m = value & 6'h3F;
    endtask

    initial begin
        int nc, pick, kind, a, b;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // node limit left at its reset value
        push_run();
        push_edge(0, 0);
        push_run();

        set_node_limit(4);
        push_edge(5, 1);
        set_node_limit(8);
        push_run();

        set_node_limit(32);
        push_edge(20, 3);
        set_node_limit(10);
        push_run();

        set_node_limit(32);
        push_edge(0, 31);
        push_edge(0, 1);
        push_edge(1, 31);
        push_run();
        push_run();
        push_edge(5, 6);
        push_edge(6, 5);
        push_run();
        push_edge(3, 3);
        push_run();
        push_edge(0, 31);
        push_edge(63, 0);
        push_edge(5, 63);
        push_run();

        set_node_limit(63);
        push_run();
        set_node_limit(33);
        push_run();
        set_node_limit(1);
        push_run();

        // longest chain reaches the widest layout
        set_node_limit(32);
        push_dag(32, 0);
        for (int i = 0; i < 31; i++)
            push_edge(perm[i], perm[i + 1]);
        push_edge(perm[0], perm[20]);
        push_run();

        // an out-of-range edge beyond a full edge store reports overflow
        set_node_limit(32);
        push_dag(32, 64);
        push_edge(2, 40);
        push_edge(7, 9);
        push_run();

        while (queued < 220) begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
                nc = 0;
            else if (pick < 16)
                nc = 32;
            else if (pick < 22)
                nc = $urandom_range(63, 33);
            else
                nc = $urandom_range(12, 1);
            set_node_limit(nc);
            repeat ($urandom_range(3, 1)) begin
                kind = $urandom_range(99, 0);
                if (nc >= 1 && nc <= MAX_NODES && kind < 92) begin
                    push_dag(nc, $urandom_range(nc < 6 ? 2 * nc : 12, 0));
                    if (kind >= 70 && kind < 82) begin
                        if (nc < 2) begin
                            push_edge(perm[0], perm[0]);
                        end else begin
                            a = $urandom_range(nc - 2, 0);
                            b = $urandom_range(nc - 1, a + 1);
                            push_edge(perm[a], perm[b]);
                            push_edge(perm[b], perm[a]);
                        end
                    end else if (kind >= 82) begin
                        if ($urandom_range(1, 0))
                            push_edge($urandom_range(nc - 1, 0), $urandom_range(63, nc));
                        else
                            push_edge($urandom_range(63, nc), $urandom_range(nc - 1, 0));
                    end
                end else begin
                    repeat ($urandom_range(4, 0))
                        push_edge($urandom_range(63, 0), $urandom_range(63, 0));
                end
                push_run();
            end
        end

        settle();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && placements_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/dagl_pkg.sv
design/dagl_out_stage.sv
design/dag_layer_layout.sv
tb/dag_layer_layout_tb.sv
